>>> hdl/plc_pkg.sv
// Shared types and status codes for the positional list block.
package plc_pkg;

  localparam int unsigned POS_W   = 7;
  localparam int unsigned DATA_W  = 32;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Broadcast to every cell; slot is the 0-based index the operation targets.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic [POS_W-1:0]   slot;
    logic [DATA_W-1:0]  value;
  } cmd_t;

endpackage

>>> hdl/plc_cell.sv
// One storage cell of the list: holds one element and shifts with its neighbors.
module plc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                         clk,
  input  plc_pkg::cmd_t                cmd,
  input  logic [plc_pkg::DATA_W-1:0]   left_data,
  input  logic [plc_pkg::DATA_W-1:0]   right_data,
  output logic [plc_pkg::DATA_W-1:0]   data,
  output logic [plc_pkg::DATA_W-1:0]   tap
);

  logic [31:0]                  slot_ext;
  logic                         at_slot;
  logic                         above_slot;
  logic [plc_pkg::DATA_W-1:0]   data_next;
  logic [plc_pkg::DATA_W-1:0]   tap_next;

  assign slot_ext   = 32'(cmd.slot);
  assign at_slot    = (slot_ext == 32'(IDX));
  assign above_slot = (32'(IDX) > slot_ext);

  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (at_slot) begin
        data_next = cmd.value;
      end else if (above_slot) begin
        data_next = left_data;
      end
    end else if (cmd.del) begin
      if (at_slot || above_slot) begin
        data_next = right_data;
      end
    end
  end

  assign tap_next = (cmd.del && at_slot) ? data : '0;

  always_ff @(posedge clk) begin
    data <= data_next;
    tap  <= tap_next;
  end

endmodule

>>> hdl/positional_list_insert_delete.sv
// Top level of the positional list: cell chain, length counter and result stage.
// Ordered list of signed 32-bit values in a row of CAPACITY cells. Insert
// places value before 0-based slot position (0..length); delete removes the
// element at 1-based position (1..length) and returns it. Every cell compares
// its own index with the position and shifts locally, so the list is updated
// in the cycle a transaction is taken. busy stays low: a transaction may be
// started in every cycle. Its result appears with done, for one cycle, after
// the registered cell read taps and s1 stage feed the output registers, whose
// OR of the taps yields removed_value. Rejected operations leave the list
// unchanged. The list is empty after reset; no clearing pass is needed.
module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic [6:0]         position,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] removed_value,
  output logic [6:0]         list_length
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = (CW > plc_pkg::POS_W) ? CW : plc_pkg::POS_W;

  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic           accept;
  logic [WW-1:0]  pos_w;
  logic [WW-1:0]  count_w;
  logic           ins_ok;
  logic           del_ok;
  logic [1:0]     status_next;
  plc_pkg::cmd_t  cmd;

  logic           s1_valid;
  logic [1:0]     s1_status;
  logic [CW-1:0]  s1_count;

  logic [plc_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [plc_pkg::DATA_W-1:0] cell_tap  [CAPACITY];
  logic [plc_pkg::DATA_W-1:0] tap_or;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pos_w   = WW'(position);
  assign count_w = WW'(count);

  assign ins_ok = (pos_w <= count_w) && (count_w < WW'(CAPACITY));
  assign del_ok = (pos_w != '0) && (pos_w <= count_w);

  always_comb begin
    cmd         = '0;
    cmd.value   = value;
    count_next  = count;
    status_next = plc_pkg::STATUS_DONE;
    if (func == plc_pkg::OP_INSERT) begin
      cmd.slot = position;
      if (pos_w > count_w) begin
        status_next = plc_pkg::STATUS_RANGE;
      end else if (!ins_ok) begin
        status_next = plc_pkg::STATUS_FULL;
      end else begin
        cmd.ins    = accept;
        count_next = count + CW'(1);
      end
    end else begin
      cmd.slot = position - 7'd1;
      if (!del_ok) begin
        status_next = plc_pkg::STATUS_RANGE;
      end else begin
        cmd.del    = accept;
        count_next = count - CW'(1);
      end
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [plc_pkg::DATA_W-1:0] left_d;
    logic [plc_pkg::DATA_W-1:0] right_d;
    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[k+1];
    end
    plc_cell #(
      .IDX(k)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_data (left_d),
      .right_data(right_d),
      .data      (cell_data[k]),
      .tap       (cell_tap[k])
    );
  end

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      done     <= s1_valid;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_next;
      s1_count  <= count_next;
    end
    status        <= s1_status;
    list_length   <= 7'(s1_count);
    removed_value <= tap_or;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("transaction result missing");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != plc_pkg::STATUS_DONE |-> removed_value == '0)
    else $error("rejected transaction returned a value");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    done && status == plc_pkg::STATUS_FULL |-> list_length == 7'(CAPACITY))
    else $error("full status with list not full");
`endif

endmodule

>>> bench/tb_positional_list_insert_delete.sv
// Self-checking testbench for positional_list_insert_delete against a queue list model.
module tb_positional_list_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   CAPACITY       = 64;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   SETTLE_CYCLES  = 4;
  localparam int   DATA_W         = plc_pkg::DATA_W;
  localparam int   POS_W          = plc_pkg::POS_W;
  localparam logic OP_INSERT      = plc_pkg::OP_INSERT;
  localparam logic OP_DELETE      = plc_pkg::OP_DELETE;

  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed;
    logic [POS_W-1:0]         length;
  } outcome_t;

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     start    = 1'b0;
  logic                     func     = OP_INSERT;
  logic [POS_W-1:0]         position = '0;
  logic signed [DATA_W-1:0] value    = '0;
  logic                     busy;
  logic                     done;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] removed_value;
  logic [POS_W-1:0]         list_length;

  logic signed [DATA_W-1:0] shadow_list[$];
  outcome_t                 pending_outcomes[$];
  int                       mismatches   = 0;
  int                       idle_pct     = 0;
  int                       quiet_cycles = 0;

  always #5 clk = ~clk;

  positional_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .position     (position),
    .value        (value),
    .done         (done),
    .status       (status),
    .removed_value(removed_value),
    .list_length  (list_length)
  );

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Update the list model with one accepted transaction and queue its outcome.
  task automatic apply_operation(input logic f, input int p, input logic signed [DATA_W-1:0] v);
    outcome_t o;
    int       n;
    n         = shadow_list.size();
    o.removed = '0;
    if (f == OP_INSERT) begin
      if (p > n) begin
        o.status = plc_pkg::STATUS_RANGE;
      end else if (n >= CAPACITY) begin
        o.status = plc_pkg::STATUS_FULL;
      end else begin
        shadow_list.insert(p, v);
        o.status = plc_pkg::STATUS_DONE;
      end
    end else if (p == 0 || p > n) begin
      o.status = plc_pkg::STATUS_RANGE;
    end else begin
      o.removed = shadow_list[p-1];
      shadow_list.delete(p-1);
      o.status = plc_pkg::STATUS_DONE;
    end
    o.length = POS_W'(shadow_list.size());
    pending_outcomes.push_back(o);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance with start still high.
  task automatic send_item(input logic f, input int p, input logic signed [DATA_W-1:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      start    = 1'b0;
      func     = 1'($urandom);
      position = POS_W'($urandom);
      value    = DATA_W'($urandom);
      @(negedge clk);
    end
    start    = 1'b1;
    func     = f;
    position = POS_W'(p);
    value    = v;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_operation(f, p, v);
    @(negedge clk);
  endtask

  task automatic stop_and_drain();
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_item(OP_DELETE, 0, 32'sd5);
    send_item(OP_DELETE, 1, 32'sd5);
    send_item(OP_DELETE, 64, 32'sd5);
    send_item(OP_INSERT, 1, 32'sd9);
    send_item(OP_INSERT, 64, 32'sd9);
    send_item(OP_INSERT, 0, 32'sh8000_0000);
    send_item(OP_INSERT, 1, 32'sh7fff_ffff);
    send_item(OP_INSERT, 1, -32'sd1);
    send_item(OP_INSERT, 0, 32'sd0);
    send_item(OP_INSERT, 4, 32'sh5a5a_5a5a);
    send_item(OP_INSERT, 6, 32'sd3);
    send_item(OP_DELETE, 0, 32'sd0);
    send_item(OP_DELETE, 6, 32'sd0);
    send_item(OP_DELETE, 5, 32'sd0);
    send_item(OP_DELETE, 1, 32'sd0);
    send_item(OP_DELETE, 2, 32'sd0);
    send_item(OP_DELETE, 2, 32'sd0);
    send_item(OP_DELETE, 1, 32'sd0);
    send_item(OP_DELETE, 1, 32'sd0);
    stop_and_drain();
  endtask

  // Fill to capacity, hit the full and out-of-range cases, then empty the list again.
  task automatic test_full_list(input int pct);
    idle_pct = pct;
    while (shadow_list.size() < CAPACITY)
      send_item(OP_INSERT, $urandom_range(0, shadow_list.size()), rand_word());
    send_item(OP_INSERT, 0, rand_word());
    send_item(OP_INSERT, CAPACITY, rand_word());
    send_item(OP_INSERT, 32, rand_word());
    send_item(OP_DELETE, CAPACITY, 32'sd0);
    send_item(OP_INSERT, CAPACITY, 32'sd0);
    send_item(OP_INSERT, CAPACITY - 1, rand_word());
    send_item(OP_DELETE, 0, 32'sd0);
    while (shadow_list.size() > 0)
      send_item(OP_DELETE, $urandom_range(1, shadow_list.size()), rand_word());
    send_item(OP_DELETE, 1, 32'sd0);
  endtask

  task automatic test_random(input int count, input int pct, input int insert_bias);
    int cnt;
    idle_pct = pct;
    repeat (count) begin
      cnt = shadow_list.size();
      if ($urandom_range(0, 99) < 10) begin
        send_item(1'($urandom), $urandom_range(0, CAPACITY), rand_word());
      end else if ($urandom_range(0, 99) < insert_bias || cnt == 0) begin
        send_item(OP_INSERT, $urandom_range(0, cnt), rand_word());
      end else begin
        send_item(OP_DELETE, $urandom_range(1, cnt), rand_word());
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no transaction pending: status %0d removed_value %0d list_length %0d",
               status, removed_value, list_length);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          mismatches++;
        end
        if (removed_value !== want.removed) begin
          $error("removed_value: expected %0d, actual %0d", want.removed, removed_value);
          mismatches++;
        end
        if (list_length !== want.length) begin
          $error("list_length: expected %0d, actual %0d", want.length, list_length);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_list(0);
    test_random(200, 0, 70);
    test_random(200, 0, 30);
    test_random(250, 46, 75);
    test_random(250, 46, 25);
    stop_and_drain();
    test_full_list(24);
    test_random(150, 24, 80);
    test_random(150, 24, 20);
    test_random(150, 0, 50);

    stop_and_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/plc_pkg.sv
hdl/plc_cell.sv
hdl/positional_list_insert_delete.sv
bench/tb_positional_list_insert_delete.sv
